[design/grs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the Gaussian rigid skinning block.
// No dependencies; used by every module of the block and its checker.
package grs_pkg;

  // table and word geometry
  localparam int MAX_VERTICES_DEF = 16384;
  localparam int WORD_W           = 32;
  localparam int FRAC_W           = 16;
  localparam int ROWS             = 3;
  localparam int COLS             = 4;
  localparam int ROW_W            = WORD_W * COLS;
  localparam int VIDX_W           = 17;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DEFORM = 1'b1
  } opcode_t;

  // square root and divider widths
  localparam int SQ1_IN_W   = 48;                       // clamped diagonal sum << 14
  localparam int SQ1_OUT_W  = SQ1_IN_W / 2;
  localparam int SQ2_IN_W   = 50;                       // sum of four squares
  localparam int SQ2_OUT_W  = SQ2_IN_W / 2;
  localparam int DIV_NUM_W  = SQ1_OUT_W + FRAC_W + 1;
  localparam int DIV_DEN_W  = SQ2_OUT_W;
  localparam int DIV_Q_W    = FRAC_W + 1;
  localparam int A_W        = DIV_Q_W + 1;

  // pipeline stage numbers, counted in edges after the accepting edge
  localparam int ST_D     = 1;
  localparam int ST_Q     = ST_D + SQ1_OUT_W;
  localparam int ST_SQR   = ST_Q + 1;
  localparam int ST_SS    = ST_SQR + 1;
  localparam int ST_N     = ST_SS + SQ2_OUT_W;
  localparam int ST_NUM   = ST_N + 1;
  localparam int ST_A     = ST_NUM + DIV_Q_W;
  localparam int ST_PROD  = ST_A + 1;
  localparam int ST_OUT   = ST_PROD + 1;
  localparam int PIPE_LAT = ST_OUT + 1;

endpackage

[design/grs_isqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on grs_pkg for its default width.
module grs_isqrt #(
  parameter int IN_W = grs_pkg::SQ1_IN_W
) (
  input  logic                clk,
  input  logic [IN_W-1:0]     radicand,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 3;

  logic [REM_W-1:0] rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];
  logic [IN_W-1:0]  rest_r [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_in, rem_sh, trial;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  rest_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rest_in = rest_r[k-1];
    end

    // bring down two bits, try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rest_in[IN_W-1 -: 2]};
    assign trial  = {{(REM_W-OUT_W-2){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rem_sh >= trial) begin
        rem_r[k]  <= rem_sh - trial;
        root_r[k] <= {root_in[OUT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rem_sh;
        root_r[k] <= {root_in[OUT_W-2:0], 1'b0};
      end
      rest_r[k] <= {rest_in[IN_W-3:0], 2'b00};
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

[design/grs_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient must fit Q_W bits. Depends on grs_pkg for default widths.
module grs_div #(
  parameter int NUM_W = grs_pkg::DIV_NUM_W,
  parameter int DEN_W = grs_pkg::DIV_DEN_W,
  parameter int Q_W   = grs_pkg::DIV_Q_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CMP_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int SH = Q_W - 1 - k;
    logic [CMP_W-1:0] rem_in, cand;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;

    if (k == 0) begin : g_first
      assign rem_in = CMP_W'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign cand = CMP_W'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (rem_in >= cand) begin
        rem_r[k] <= rem_in - cand;
        q_r[k]   <= {q_in[Q_W-2:0], 1'b1};
      end else begin
        rem_r[k] <= rem_in;
        q_r[k]   <= {q_in[Q_W-2:0], 1'b0};
      end
      den_r[k] <= den_in;
    end
  end

  assign quot = q_r[Q_W-1];

endmodule

[design/gaussian_rigid_skinning.sv]
`timescale 1ns / 1ps
// Gaussian rigid skinning: per-vertex transform table, posed position and quaternion.
// Depends on grs_pkg, grs_isqrt and grs_div.
//
// The block takes one word per clock: busy stays low, so any start is accepted.
// A load writes one transform row (3 rotation entries and a translation) into
// one of three row memories (none for row index 3) and returns nothing. A deform
// reads all three rows of its vertex. Its out_valid strobe rises together with
// its result on the outputs. One result can leave every cycle. Two bit-serial
// square-root pipelines (24 and 25 stages) and a 17-stage divider for the
// normalization, plus memory read and multiply stages, make up the pipeline.
// Results cannot be held off, so take them on the strobe. The
// table is not cleared at reset: deform only vertices whose three rows were loaded.
module gaussian_rigid_skinning #(
  parameter int MAX_VERTICES = grs_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [13:0]        in_vertex_index,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_word_0,
  input  logic signed [31:0] in_word_1,
  input  logic signed [31:0] in_word_2,
  input  logic signed [31:0] in_word_3,
  input  logic signed [31:0] in_canon_x,
  input  logic signed [31:0] in_canon_y,
  input  logic signed [31:0] in_canon_z,
  output logic               out_valid,
  output logic signed [31:0] out_posed_x,
  output logic signed [31:0] out_posed_y,
  output logic signed [31:0] out_posed_z,
  output logic signed [31:0] out_posed_qw,
  output logic signed [31:0] out_posed_qx,
  output logic signed [31:0] out_posed_qy,
  output logic signed [31:0] out_posed_qz
);

  localparam int ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int ROWS    = grs_pkg::ROWS;
  localparam int ROW_W   = grs_pkg::ROW_W;
  localparam int VIDX_W  = grs_pkg::VIDX_W;
  localparam int S1_W    = grs_pkg::SQ1_OUT_W;
  localparam int S2_W    = grs_pkg::SQ2_OUT_W;
  localparam int NUM_W   = grs_pkg::DIV_NUM_W;
  localparam int Q_W     = grs_pkg::DIV_Q_W;
  localparam int A_W     = grs_pkg::A_W;
  localparam int FRAC_W  = grs_pkg::FRAC_W;
  localparam int ST_Q    = grs_pkg::ST_Q;
  localparam int ST_N    = grs_pkg::ST_N;
  localparam int ST_A    = grs_pkg::ST_A;
  localparam int ST_PROD = grs_pkg::ST_PROD;
  localparam int ST_OUT  = grs_pkg::ST_OUT;
  localparam int W_DLY   = ST_A + 1;
  localparam int NEG_DLY = ST_A;
  localparam int MAG_DLY = ST_N - ST_Q;
  localparam int POS_DLY = ST_PROD - 2;

  function automatic logic signed [31:0] sat_q(input logic signed [66:0] v);
    logic signed [66:0] hi_lim, lo_lim;
    hi_lim = 67'sd2147483647;
    lo_lim = -67'sd2147483648;
    if (v > hi_lim)      sat_q = 32'sh7FFF_FFFF;
    else if (v < lo_lim) sat_q = 32'sh8000_0000;
    else                 sat_q = v[31:0];
  endfunction

  // ---------------- input decode ----------------
  logic              accept, in_range, wr_en, deform;
  logic [VIDX_W-1:0] vidx_ext;
  logic [ADDR_W-1:0] addr;
  logic [ROW_W-1:0]  wr_data;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign vidx_ext = VIDX_W'(in_vertex_index);
  assign in_range = vidx_ext < VIDX_W'(MAX_VERTICES);
  assign addr     = vidx_ext[ADDR_W-1:0];
  assign wr_en    = accept && in_range && (in_opcode == grs_pkg::OP_LOAD);
  assign deform   = accept && in_range && (in_opcode == grs_pkg::OP_DEFORM);
  assign wr_data  = {in_word_3, in_word_2, in_word_1, in_word_0};

  // ---------------- transform rows, one memory per row ----------------
  logic [ROW_W-1:0] rd_row_r [ROWS];

  for (genvar g = 0; g < ROWS; g++) begin : g_row
    logic [ROW_W-1:0] row_mem [MAX_VERTICES];
    always_ff @(posedge clk) begin
      if (wr_en && (in_row_index == 2'(g))) row_mem[addr] <= wr_data;
      rd_row_r[g] <= row_mem[addr];
    end
  end

  // ---------------- valid line ----------------
  logic valid_r [ST_OUT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ST_OUT; k++) valid_r[k] <= 1'b0;
    end else begin
      valid_r[0] <= deform;
      for (int k = 1; k <= ST_OUT; k++) valid_r[k] <= valid_r[k-1];
    end
  end

  // ---------------- stage 0: canonical position ----------------
  logic signed [31:0] p0_r [3];

  always_ff @(posedge clk) begin
    p0_r[0] <= in_canon_x;
    p0_r[1] <= in_canon_y;
    p0_r[2] <= in_canon_z;
  end

  logic signed [31:0] rm [3][3];
  logic signed [31:0] tv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) rm[i][j] = rd_row_r[i][32*j +: 32];
      tv[i] = rd_row_r[i][96 +: 32];
    end
  end

  // ---------------- stage 1: position products, Shepperd sums ----------------
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] t1_r   [3];
  logic signed [34:0] dv     [4];
  logic [2*S1_W-1:0]  sq_in_r [4];
  logic signed [32:0] dx, dy, dz;
  logic [2:0]         neg0;

  always_comb begin
    dv[0] = 35'sd65536 + 35'(rm[0][0]) + 35'(rm[1][1]) + 35'(rm[2][2]);
    dv[1] = 35'sd65536 + 35'(rm[0][0]) - 35'(rm[1][1]) - 35'(rm[2][2]);
    dv[2] = 35'sd65536 - 35'(rm[0][0]) + 35'(rm[1][1]) - 35'(rm[2][2]);
    dv[3] = 35'sd65536 - 35'(rm[0][0]) - 35'(rm[1][1]) + 35'(rm[2][2]);
    dx    = 33'(rm[2][1]) - 33'(rm[1][2]);
    dy    = 33'(rm[0][2]) - 33'(rm[2][0]);
    dz    = 33'(rm[1][0]) - 33'(rm[0][1]);
    neg0  = {dz[32], dy[32], dx[32]};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) prod_r[i][j] <= rm[i][j] * p0_r[j];
      t1_r[i] <= tv[i];
    end
    // negative sums clamp to zero; scale by 2^14 for 0.5*sqrt
    for (int k = 0; k < 4; k++)
      sq_in_r[k] <= dv[k][34] ? '0 : {1'b0, dv[k][32:0], 14'b0};
  end

  // ---------------- stage 2: posed position ----------------
  logic signed [31:0] pos_r [3];
  logic signed [65:0] psum  [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      psum[i] = 66'(prod_r[i][0]) + 66'(prod_r[i][1]) + 66'(prod_r[i][2]) + 66'sd32768;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      pos_r[i] <= sat_q(67'(psum[i] >>> FRAC_W) + 67'(t1_r[i]));
  end

  // ---------------- Shepperd magnitudes ----------------
  logic [S1_W-1:0] mag [4];

  for (genvar k = 0; k < 4; k++) begin : g_sq1
    grs_isqrt #(.IN_W(grs_pkg::SQ1_IN_W)) u_sq1 (
      .clk      (clk),
      .radicand (sq_in_r[k]),
      .root     (mag[k])
    );
  end

  // squares, then their sum
  logic [2*S1_W-1:0] sqr_r [4];
  logic [2*S2_W-1:0] ss_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) sqr_r[k] <= (2*S1_W)'(mag[k]) * (2*S1_W)'(mag[k]);
    ss_r <= (2*S2_W)'(sqr_r[0]) + (2*S2_W)'(sqr_r[1]) + (2*S2_W)'(sqr_r[2])
          + (2*S2_W)'(sqr_r[3]);
  end

  logic [S2_W-1:0] norm;

  grs_isqrt #(.IN_W(grs_pkg::SQ2_IN_W)) u_sq2 (
    .clk      (clk),
    .radicand (ss_r),
    .root     (norm)
  );

  // magnitudes wait for the norm
  logic [4*S1_W-1:0] mag_dl_r [MAG_DLY];

  always_ff @(posedge clk) begin
    mag_dl_r[0] <= {mag[3], mag[2], mag[1], mag[0]};
    for (int k = 1; k < MAG_DLY; k++) mag_dl_r[k] <= mag_dl_r[k-1];
  end

  // ---------------- normalize: rounded |q| * 2^16 / norm ----------------
  logic [S2_W-1:0]  norm_c, den_r;
  logic [NUM_W-1:0] num_r [4];

  assign norm_c = (norm == '0) ? S2_W'(1) : norm;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++)
      num_r[k] <= NUM_W'({mag_dl_r[MAG_DLY-1][S1_W*k +: S1_W], {FRAC_W{1'b0}}})
                + NUM_W'(norm_c >> 1);
    den_r <= norm_c;
  end

  logic [Q_W-1:0] quot [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    grs_div #(
      .NUM_W (NUM_W),
      .DEN_W (grs_pkg::DIV_DEN_W),
      .Q_W   (Q_W)
    ) u_div (
      .clk  (clk),
      .num  (num_r[k]),
      .den  (den_r),
      .quot (quot[k])
    );
  end

  // canonical quaternion and the signs travel alongside
  logic [ROW_W-1:0] w_dl_r   [W_DLY];
  logic [2:0]       neg_dl_r [NEG_DLY];

  always_ff @(posedge clk) begin
    w_dl_r[0]   <= wr_data;
    neg_dl_r[0] <= neg0;
    for (int k = 1; k < W_DLY; k++)   w_dl_r[k]   <= w_dl_r[k-1];
    for (int k = 1; k < NEG_DLY; k++) neg_dl_r[k] <= neg_dl_r[k-1];
  end

  // ---------------- Hamilton products ----------------
  logic signed [A_W-1:0]   av [4];
  logic signed [31:0]      wv [4];
  logic signed [A_W+31:0]  hp_r [4][4];
  logic [3:0]              neg_a;

  assign neg_a = {neg_dl_r[NEG_DLY-1], 1'b0};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      av[k] = neg_a[k] ? -$signed({1'b0, quot[k]}) : $signed({1'b0, quot[k]});
      wv[k] = w_dl_r[W_DLY-1][32*k +: 32];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) hp_r[i][j] <= av[i] * wv[j];
  end

  // posed position waits for the quaternion
  logic signed [31:0] pos_dl_r [POS_DLY][3];

  always_ff @(posedge clk) begin
    pos_dl_r[0] <= pos_r;
    for (int k = 1; k < POS_DLY; k++) pos_dl_r[k] <= pos_dl_r[k-1];
  end

  // ---------------- output stage: sum, round, saturate ----------------
  logic signed [A_W+33:0] hsum [4];

  always_comb begin
    hsum[0] = (A_W+34)'(hp_r[0][0]) - (A_W+34)'(hp_r[1][1])
            - (A_W+34)'(hp_r[2][2]) - (A_W+34)'(hp_r[3][3]);
    hsum[1] = (A_W+34)'(hp_r[0][1]) + (A_W+34)'(hp_r[1][0])
            + (A_W+34)'(hp_r[2][3]) - (A_W+34)'(hp_r[3][2]);
    hsum[2] = (A_W+34)'(hp_r[0][2]) - (A_W+34)'(hp_r[1][3])
            + (A_W+34)'(hp_r[2][0]) + (A_W+34)'(hp_r[3][1]);
    hsum[3] = (A_W+34)'(hp_r[0][3]) + (A_W+34)'(hp_r[1][2])
            - (A_W+34)'(hp_r[2][1]) + (A_W+34)'(hp_r[3][0]);
  end

  logic signed [31:0] oq_r [4];
  logic signed [31:0] op_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++)
      oq_r[k] <= sat_q(67'((hsum[k] + (A_W+34)'(32768)) >>> FRAC_W));
    op_r <= pos_dl_r[POS_DLY-1];
  end

  assign out_valid    = valid_r[ST_OUT];
  assign out_posed_x  = op_r[0];
  assign out_posed_y  = op_r[1];
  assign out_posed_z  = op_r[2];
  assign out_posed_qw = oq_r[0];
  assign out_posed_qx = oq_r[1];
  assign out_posed_qy = oq_r[2];
  assign out_posed_qz = oq_r[3];

endmodule

[design/grs_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for gaussian_rigid_skinning, bound to the top level.
// Depends on grs_pkg for the pipeline latency and opcodes.
module grs_checker #(
  parameter int MAX_VERTICES = grs_pkg::MAX_VERTICES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_opcode,
  input logic [13:0] in_vertex_index,
  input logic        out_valid
);

  localparam int LAT = grs_pkg::PIPE_LAT;

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // reset flushes every word in flight
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // each result comes from a deform word accepted a fixed latency earlier
  a_from_deform: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_opcode == grs_pkg::OP_DEFORM), LAT))
    else $error("result without deform word");

  // and that word named a vertex in range
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past({3'b000, in_vertex_index}, LAT) < 17'(MAX_VERTICES)))
    else $error("result for out-of-range vertex");

endmodule

bind gaussian_rigid_skinning grs_checker #(.MAX_VERTICES(MAX_VERTICES)) u_grs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .in_vertex_index (in_vertex_index),
  .out_valid       (out_valid)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for gaussian_rigid_skinning: directed table plus random load/deform words.
// Depends on grs_pkg and the gaussian_rigid_skinning RTL; self-checking, no files.
module tb_top;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [1:0]  ROW_UNUSED = 2'd3;
  localparam int N_RANDOM  = 1630;
  localparam int POOL_SZ   = 24;
  localparam int TAIL_WAIT = 100;

  typedef logic [6:0][31:0] pose_t;

  typedef struct {
    grs_pkg::opcode_t op;
    logic [13:0]      vtx;
    logic [1:0]       row;
    logic [3:0][31:0] wd;
    logic [2:0][31:0] cn;
    bit               typed;
    pose_t            pose;
  } stim_t;

  logic clk, rst_n, start, busy;
  logic in_opcode;
  logic [13:0] in_vertex_index;
  logic [1:0] in_row_index;
  logic signed [31:0] in_word_0, in_word_1, in_word_2, in_word_3;
  logic signed [31:0] in_canon_x, in_canon_y, in_canon_z;
  logic out_valid;
  logic signed [31:0] out_posed_x, out_posed_y, out_posed_z;
  logic signed [31:0] out_posed_qw, out_posed_qx, out_posed_qy, out_posed_qz;

  // typed expectation travels with the word it belongs to
  bit    typed_flag;
  pose_t typed_pose;

  logic [31:0] xform_tab [int];
  pose_t       pose_fifo [$];
  int          errors, n_loads, n_deforms, n_checked;
  string       field_name [7] = '{"posed_x", "posed_y", "posed_z",
                                  "posed_qw", "posed_qx", "posed_qy", "posed_qz"};

  gaussian_rigid_skinning DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_vertex_index(in_vertex_index),
    .in_row_index(in_row_index),
    .in_word_0(in_word_0), .in_word_1(in_word_1),
    .in_word_2(in_word_2), .in_word_3(in_word_3),
    .in_canon_x(in_canon_x), .in_canon_y(in_canon_y), .in_canon_z(in_canon_z),
    .out_valid(out_valid),
    .out_posed_x(out_posed_x), .out_posed_y(out_posed_y), .out_posed_z(out_posed_z),
    .out_posed_qw(out_posed_qw), .out_posed_qx(out_posed_qx),
    .out_posed_qy(out_posed_qy), .out_posed_qz(out_posed_qz)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return SMAX;
    if (v < -64'sh8000_0000) return SMIN;
    return v[31:0];
  endfunction

  function automatic longint half_mag(longint d);
    if (d < 0) d = 0;
    return longint'(int_sqrt(longint'(d) << 14));
  endfunction

  function automatic pose_t pose_splat(logic [13:0] vtx, logic [3:0][31:0] wd,
                                       logic [2:0][31:0] cn);
    longint r [3][3];
    longint t [3];
    longint p [3];
    longint b [4];
    longint q [4];
    longint a [4];
    longint h [4];
    longint hi, lo, prod;
    longint unsigned ss, nrm, m, rq;
    int base;
    pose_t res;
    base = int'(vtx) * 12;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) r[i][j] = longint'($signed(xform_tab[base + i*4 + j]));
      t[i] = longint'($signed(xform_tab[base + i*4 + 3]));
      p[i] = longint'($signed(cn[i]));
    end
    for (int i = 0; i < 4; i++) b[i] = longint'($signed(wd[i]));
    // position: split high/low sums so three full products cannot overflow
    for (int i = 0; i < 3; i++) begin
      hi = 0;
      lo = 0;
      for (int j = 0; j < 3; j++) begin
        prod = r[i][j] * p[j];
        hi += prod >>> 16;
        lo += prod & 64'hFFFF;
      end
      lo += 64'h8000;
      res[i] = sat32(hi + (lo >>> 16) + t[i]);
    end
    // Shepperd magnitudes, signs from off-diagonal differences (zero is positive)
    q[0] = half_mag(65536 + r[0][0] + r[1][1] + r[2][2]);
    q[1] = half_mag(65536 + r[0][0] - r[1][1] - r[2][2]);
    q[2] = half_mag(65536 - r[0][0] + r[1][1] - r[2][2]);
    q[3] = half_mag(65536 - r[0][0] - r[1][1] + r[2][2]);
    if (r[2][1] - r[1][2] < 0) q[1] = -q[1];
    if (r[0][2] - r[2][0] < 0) q[2] = -q[2];
    if (r[1][0] - r[0][1] < 0) q[3] = -q[3];
    ss = 0;
    for (int i = 0; i < 4; i++) ss += longint'(q[i] * q[i]);
    nrm = int_sqrt(ss);
    if (nrm < 1) nrm = 1;
    // normalize, ties away from zero
    for (int i = 0; i < 4; i++) begin
      m = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
      rq = ((m << 16) + (nrm >> 1)) / nrm;
      a[i] = (q[i] < 0) ? -longint'(rq) : longint'(rq);
    end
    h[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    h[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    h[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    h[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    // signed rounding constant keeps the shift arithmetic
    for (int i = 0; i < 4; i++) res[3 + i] = sat32((h[i] + 64'sh8000) >>> 16);
    return res;
  endfunction

  // ---------------- checker and table mirror ----------------
  always @(posedge clk) begin
    pose_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pose_fifo.size() == 0) begin
          $error("result word with no expectation pending");
          errors++;
        end else begin
          want = pose_fifo.pop_front();
          n_checked++;
          for (int i = 0; i < 7; i++) begin
            logic [31:0] got;
            case (i)
              0: got = out_posed_x;
              1: got = out_posed_y;
              2: got = out_posed_z;
              3: got = out_posed_qw;
              4: got = out_posed_qx;
              5: got = out_posed_qy;
              default: got = out_posed_qz;
            endcase
            if (got !== want[i]) begin
              $error("%s: expected %h, got %h", field_name[i], want[i], got);
              errors++;
            end
          end
        end
      end
      if (start && !busy && in_vertex_index < grs_pkg::MAX_VERTICES_DEF) begin
        if (grs_pkg::opcode_t'(in_opcode) == grs_pkg::OP_LOAD) begin
          n_loads++;
          if (in_row_index != ROW_UNUSED) begin
            xform_tab[int'(in_vertex_index)*12 + int'(in_row_index)*4 + 0] = in_word_0;
            xform_tab[int'(in_vertex_index)*12 + int'(in_row_index)*4 + 1] = in_word_1;
            xform_tab[int'(in_vertex_index)*12 + int'(in_row_index)*4 + 2] = in_word_2;
            xform_tab[int'(in_vertex_index)*12 + int'(in_row_index)*4 + 3] = in_word_3;
          end
        end else begin
          n_deforms++;
          if (typed_flag) pose_fifo.insert(pose_fifo.size(), typed_pose);
          else pose_fifo.insert(pose_fifo.size(), pose_splat(in_vertex_index,
                 {in_word_3, in_word_2, in_word_1, in_word_0},
                 {in_canon_z, in_canon_y, in_canon_x}));
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic stim_t mk(grs_pkg::opcode_t op, logic [13:0] vtx, logic [1:0] row,
                               logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                               logic [31:0] w3, logic [31:0] cx, logic [31:0] cy,
                               logic [31:0] cz);
    stim_t s;
    s.op = op; s.vtx = vtx; s.row = row;
    s.wd[0] = w0; s.wd[1] = w1; s.wd[2] = w2; s.wd[3] = w3;
    s.cn[0] = cx; s.cn[1] = cy; s.cn[2] = cz;
    s.typed = 1'b0;
    s.pose = '0;
    return s;
  endfunction

  function automatic stim_t with_pose(stim_t s, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [31:0] qw);
    s.typed = 1'b1;
    s.pose[0] = x; s.pose[1] = y; s.pose[2] = z;
    s.pose[3] = qw; s.pose[4] = '0; s.pose[5] = '0; s.pose[6] = '0;
    return s;
  endfunction

  task automatic send_word(stim_t s, int gap);
    in_opcode       <= s.op;
    in_vertex_index <= s.vtx;
    in_row_index    <= s.row;
    in_word_0  <= s.wd[0]; in_word_1 <= s.wd[1];
    in_word_2  <= s.wd[2]; in_word_3 <= s.wd[3];
    in_canon_x <= s.cn[0]; in_canon_y <= s.cn[1]; in_canon_z <= s.cn[2];
    typed_flag <= s.typed;
    typed_pose <= s.pose;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rot_entry(int kind);
    case (kind)
      0: return 32'($urandom_range(0, 131072)) - ONE;
      1: case ($urandom_range(0, 2))
           0: return '0;
           1: return ONE;
           default: return -ONE;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(int span);
    if ($urandom_range(0, 9) < 7) return 32'($urandom_range(0, 2*span)) - 32'(span);
    return $urandom;
  endfunction

  stim_t dir_tab [$];
  logic [13:0] vpool [POOL_SZ];
  logic [2:0]  rows_done [POOL_SZ];
  int wd_kind [POOL_SZ];

  function automatic void add_row(stim_t s);
    dir_tab.insert(dir_tab.size(), s);
  endfunction

  initial begin
    stim_t s;
    int k, gap, burst, drain_cnt;
    errors = 0; n_loads = 0; n_deforms = 0; n_checked = 0;
    rst_n = 1'b0; start = 1'b0; in_opcode = 1'b0; in_vertex_index = '0;
    in_row_index = '0; in_word_0 = '0; in_word_1 = '0; in_word_2 = '0; in_word_3 = '0;
    in_canon_x = '0; in_canon_y = '0; in_canon_z = '0;
    typed_flag = 1'b0; typed_pose = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity at vertex 0: posed position equals the input, rotation is the unit quaternion
    add_row(mk(grs_pkg::OP_LOAD, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 0, 1, 0, ONE, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 0, 2, 0, 0, ONE, 0, 0, 0, 0));
    add_row(with_pose(mk(grs_pkg::OP_DEFORM, 0, 0, ONE, 0, 0, 0,
            32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000),
            32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, ONE));
    add_row(with_pose(mk(grs_pkg::OP_DEFORM, 0, 2, ONE, 0, 0, 0, SMAX, SMIN, 0),
            SMAX, SMIN, 0, ONE));
    // row index three is dropped, vertex 0 stays identity
    add_row(mk(grs_pkg::OP_LOAD, 0, ROW_UNUSED, SMIN, SMAX, SMIN, SMAX, 0, 0, 0));
    add_row(with_pose(mk(grs_pkg::OP_DEFORM, 0, 0, ONE, 0, 0, 0, 0, 0, 0), 0, 0, 0, ONE));
    // identity with extreme translation: position saturates both ways
    add_row(mk(grs_pkg::OP_LOAD, 2, 0, ONE, 0, 0, SMAX, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 2, 1, 0, ONE, 0, SMIN, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 2, 2, 0, 0, ONE, 0, 0, 0, 0));
    add_row(with_pose(mk(grs_pkg::OP_DEFORM, 2, 0, ONE, 0, 0, 0, SMAX, SMIN, 0),
            SMAX, SMIN, 0, ONE));
    // extreme entries at the top vertex
    add_row(mk(grs_pkg::OP_LOAD, 14'h3FFF, 0, SMAX, SMIN, 0, SMAX, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 14'h3FFF, 1, SMIN, SMAX, 32'hFFFF_FFFF, SMIN, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 14'h3FFF, 2, 0, 1, SMAX, SMAX, 0, 0, 0));
    add_row(mk(grs_pkg::OP_DEFORM, 14'h3FFF, 1, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
    add_row(mk(grs_pkg::OP_DEFORM, 14'h3FFF, 3, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN, SMIN));
    // zero matrix: all four magnitudes equal, zero differences count as positive
    add_row(mk(grs_pkg::OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 1, 2, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_DEFORM, 1, 0, ONE, ONE, -ONE, SMIN, ONE, ONE, ONE));
    // half-turn about x: only the x magnitude survives (the all-zero quaternion
    // cannot occur, the four diagonal sums always add to four)
    add_row(mk(grs_pkg::OP_LOAD, 3, 0, ONE, 0, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 3, 1, 0, -ONE, 0, 0, 0, 0, 0));
    add_row(mk(grs_pkg::OP_LOAD, 3, 2, 0, 0, -ONE, ONE, 0, 0, 0));
    add_row(mk(grs_pkg::OP_DEFORM, 3, 0, 0, ONE, 0, 0, ONE, -ONE, ONE));

    foreach (dir_tab[i]) send_word(dir_tab[i], $urandom_range(0, 4));

    // random phase over a small pool of vertices; deform only fully loaded ones
    vpool[0] = '0;
    vpool[1] = 14'h3FFF;
    for (int i = 2; i < POOL_SZ; i++) vpool[i] = 14'($urandom);
    for (int i = 0; i < POOL_SZ; i++) begin
      rows_done[i] = '0;
      wd_kind[i] = $urandom_range(0, 3);
    end
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, POOL_SZ - 1);
      if (rows_done[k] != 3'b111 || $urandom_range(0, 9) < 4) begin
        s = mk(grs_pkg::OP_LOAD, vpool[k], 2'($urandom_range(0, 2)), 0, 0, 0, 0,
               $urandom, $urandom, $urandom);
        if ($urandom_range(0, 19) == 0) s.row = ROW_UNUSED;
        if ($urandom_range(0, 5) == 0) wd_kind[k] = $urandom_range(0, 3);
        for (int c = 0; c < 3; c++) s.wd[c] = rot_entry(wd_kind[k] > 2 ? 0 : wd_kind[k]);
        s.wd[3] = rand_coord(1 << 20);
        // two pool slots can share an index, so keep both slots in step
        if (s.row != ROW_UNUSED)
          for (int i = 0; i < POOL_SZ; i++)
            if (vpool[i] == s.vtx) rows_done[i][s.row] = 1'b1;
      end else begin
        s = mk(grs_pkg::OP_DEFORM, vpool[k], 2'($urandom), rand_coord(ONE), rand_coord(ONE),
               rand_coord(ONE), rand_coord(ONE), rand_coord(1 << 22),
               rand_coord(1 << 22), rand_coord(1 << 22));
      end
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 29) == 0) burst = $urandom_range(10, 40);
      end
      send_word(s, gap);
      // hold off once until the pipeline is empty
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pose_fifo.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    drain_cnt = 0;
    while (pose_fifo.size() != 0 && drain_cnt < 10000) begin
      @(posedge clk);
      drain_cnt++;
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (pose_fifo.size() != 0) begin
      $error("%0d expected results never arrived", pose_fifo.size());
      errors++;
    end
    $display("Covered %0d loads and %0d deforms; %0d results checked, %0d mismatches.",
             n_loads, n_deforms, n_checked, errors);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
